// ===== hdl/ffpa_pkg.sv =====
package ffpa_pkg;

    // Field widths of the two channels and of the pool size register.
    localparam int OPCODE_W = 2;
    localparam int REQ_W    = 13;
    localparam int OFF_W    = 12;
    localparam int CFG_W    = 13;
    localparam int PAY_W    = 12;

    // Pool storage: 32-bit words, 8-byte block headers.
    localparam int WORD_W       = 32;
    localparam int HEADER_BYTES = 8;
    localparam int POOL_BYTES_DEF = 4096;

    // Byte addresses during a walk may run past the pool by up to one
    // full 32-bit size word, so they carry one extra bit.
    localparam int ADR_W = 33;

    // Rounded request and request plus header.
    localparam int RQ_W = 14;

    // Pool size handling for initialize.
    localparam int                 SIZE_CAP      = 4096;
    localparam int                 MIN_POOL      = 16;
    localparam logic [CFG_W-1:0]   POOL_SIZE_RST = 13'd4096;

    // Header flag bits.
    localparam logic [WORD_W-1:0] FLAG_FREE = 32'h0000_0001;
    localparam logic [WORD_W-1:0] FLAG_USED = 32'h0000_0002;
    localparam logic [WORD_W-1:0] FLAG_LAST = 32'h0000_0004;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_CHK,
        ST_A_RDS,
        ST_A_LATS,
        ST_A_EVAL,
        ST_M_RDF,
        ST_M_RDS,
        ST_M_SUM,
        ST_M_LAST,
        ST_SP_NX,
        ST_SP_W0,
        ST_SP_W1,
        ST_SP_W2,
        ST_SP_W3,
        ST_EX_W,
        ST_F_RD,
        ST_F_WR,
        ST_I_W0,
        ST_I_W1,
        ST_DONE
    } t_state;

endpackage

// ===== hdl/ffpa_if.sv =====
interface ffpa_in_if;
    logic                           valid;
    logic                           ready;
    logic [ffpa_pkg::OPCODE_W-1:0]  opcode;
    logic [ffpa_pkg::REQ_W-1:0]     request_size;
    logic [ffpa_pkg::OFF_W-1:0]     block_offset;

    modport source (output valid, output opcode, output request_size,
                    output block_offset, input ready);
    modport sink   (input valid, input opcode, input request_size,
                    input block_offset, output ready);
endinterface

interface ffpa_out_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [ffpa_pkg::PAY_W-1:0]  payload_offset;

    modport source (output valid, output status, output payload_offset, input ready);
    modport sink   (input valid, input status, input payload_offset, output ready);
endinterface

// ===== hdl/ffpa_alu.sv =====
module ffpa_alu (
    input  ffpa_pkg::t_alu_op             i_op,
    input  logic [ffpa_pkg::ADR_W-1:0]    i_a,
    input  logic [ffpa_pkg::ADR_W-1:0]    i_b,
    output logic [ffpa_pkg::ADR_W-1:0]    o_sum
);

    logic [ffpa_pkg::ADR_W-1:0] b_eff;
    logic                       carry_in;

    // One adder serves both directions: a subtract inverts b and adds one.
    assign carry_in = (i_op == ffpa_pkg::ALU_SUB);
    assign b_eff    = carry_in ? ~i_b : i_b;
    assign o_sum    = i_a + b_eff + {{(ffpa_pkg::ADR_W-1){1'b0}}, carry_in};

endmodule

// ===== hdl/ffpa_mem.sv =====
module ffpa_mem #(
    parameter int DEPTH = ffpa_pkg::POOL_BYTES_DEF / 4,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_addr,
    input  logic [ffpa_pkg::WORD_W-1:0]   i_wdata,
    output logic [ffpa_pkg::WORD_W-1:0]   o_rdata
);

    logic [ffpa_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_addr];
        end
    end

endmodule

// ===== hdl/first_fit_pool_allocator.sv =====
// Channel    | Dir | Handshake     | Word contents
// -----------+-----+---------------+-----------------------------------------------
// i_alloc    | in  | valid/ready   | opcode, request_size, block_offset
// o_result   | out | valid/ready   | status, payload_offset
// i_cfg_*    | in  | write enable  | pool_size (13 bits), used by initialize
//
// Allocate reads both words of each header it visits and may lazily merge a free
// neighbor into it; an exact fit then writes one header and a split two. Free
// updates one header unless rejected, initialize writes two words and opcode 3
// only returns a result. After reset a clearing pass writes the pool; no word
// is taken meanwhile, but pool_size writes are.
// A finished result waits in the output register, so a new word may be taken.
module first_fit_pool_allocator #(
    parameter int POOL_BYTES = ffpa_pkg::POOL_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ffpa_in_if.sink                     i_alloc,
    ffpa_out_if.source                  o_result,
    input  logic                        i_cfg_we,
    input  logic [ffpa_pkg::CFG_W-1:0]  i_cfg_wdata
);

    // Pool geometry follows the pool size in bytes.
    localparam int POOL_WORDS = POOL_BYTES / 4;
    localparam int AW         = $clog2(POOL_WORDS);
    // A walk gives up after this many header visits.
    localparam int MAX_WALK   = POOL_BYTES / 4 + 4;
    localparam int SW         = $clog2(MAX_WALK + 1);
    // A header fits when its byte offset plus the header stays inside the pool.
    localparam int FIT_MAX    = POOL_BYTES - ffpa_pkg::HEADER_BYTES;
    // Largest pool that initialize will build.
    localparam int CAP_RAW    = (POOL_BYTES / 8) * 8;
    localparam int CAP        = (CAP_RAW < ffpa_pkg::SIZE_CAP) ? CAP_RAW : ffpa_pkg::SIZE_CAP;

    localparam logic [ffpa_pkg::ADR_W-1:0]  FIT_MAX_A  = ffpa_pkg::ADR_W'(FIT_MAX);
    localparam logic [ffpa_pkg::ADR_W-1:0]  POOL_A     = ffpa_pkg::ADR_W'(POOL_BYTES);
    localparam logic [ffpa_pkg::ADR_W-1:0]  HDR_A      = ffpa_pkg::ADR_W'(ffpa_pkg::HEADER_BYTES);
    localparam logic [ffpa_pkg::CFG_W-1:0]  CAP_C      = ffpa_pkg::CFG_W'(CAP);
    localparam logic [ffpa_pkg::CFG_W-1:0]  MIN_C      = ffpa_pkg::CFG_W'(ffpa_pkg::MIN_POOL);
    localparam logic [ffpa_pkg::WORD_W-1:0] RST_SIZE_W =
        ffpa_pkg::WORD_W'(CAP - ffpa_pkg::HEADER_BYTES);
    localparam logic [SW-1:0]               MAX_WALK_C = SW'(MAX_WALK);
    localparam logic [AW-1:0]               LAST_IDX   = AW'(POOL_WORDS - 1);

    // Sequencer state and working registers.
    ffpa_pkg::t_state r_state, n_state;
    logic [AW-1:0]                  r_clr, n_clr;
    logic [ffpa_pkg::ADR_W-1:0]     r_adr, n_adr;     // header byte offset
    logic [ffpa_pkg::ADR_W-1:0]     r_nx, n_nx;       // following header
    logic [ffpa_pkg::RQ_W-1:0]      r_req, n_req;     // rounded request
    logic [ffpa_pkg::RQ_W-1:0]      r_req8, n_req8;   // request plus header
    logic [ffpa_pkg::WORD_W-1:0]    r_f, n_f;         // flag word of header
    logic [ffpa_pkg::WORD_W-1:0]    r_s, n_s;         // size word of header
    logic [ffpa_pkg::ADR_W-1:0]     r_s8, n_s8;       // size plus header
    logic                           r_big, n_big;     // size above request plus header
    logic                           r_eq, n_eq;       // size equals request
    logic                           r_nf_last, n_nf_last;
    logic [SW-1:0]                  r_steps, n_steps;
    logic                           r_res_status, n_res_status;
    logic [ffpa_pkg::PAY_W-1:0]     r_res_pay, n_res_pay;
    logic                           r_out_valid, n_out_valid;
    logic                           r_out_status, n_out_status;
    logic [ffpa_pkg::PAY_W-1:0]     r_out_pay, n_out_pay;
    logic [ffpa_pkg::CFG_W-1:0]     r_pool_size;

    // Pool memory port.
    logic                           mem_we;
    logic                           mem_re;
    logic [AW-1:0]                  mem_addr;
    logic [ffpa_pkg::WORD_W-1:0]    mem_wdata;
    logic [ffpa_pkg::WORD_W-1:0]    mem_rdata;

    // Shared adder.
    ffpa_pkg::t_alu_op              alu_op;
    logic [ffpa_pkg::ADR_W-1:0]     alu_a;
    logic [ffpa_pkg::ADR_W-1:0]     alu_b;
    logic [ffpa_pkg::ADR_W-1:0]     alu_sum;

    // Helpers derived from the registers.
    logic [AW-1:0]                  adr_idx;
    logic [AW-1:0]                  nx_idx;
    logic                           adr_fits;
    logic                           sum_fits;
    logic                           accept;
    logic [ffpa_pkg::RQ_W-1:0]      req_rnd;
    logic [ffpa_pkg::CFG_W-1:0]     ps_trunc;
    logic [ffpa_pkg::CFG_W-1:0]     ps_clamp;
    logic                           free_bad;

    assign adr_idx  = r_adr[AW+1:2];
    assign nx_idx   = r_nx[AW+1:2];
    assign adr_fits = (r_adr <= FIT_MAX_A);
    assign sum_fits = (alu_sum <= FIT_MAX_A);
    assign accept   = i_alloc.valid && i_alloc.ready;

    // Requests are rounded up to the next multiple of eight bytes.
    assign req_rnd  = (ffpa_pkg::RQ_W'(i_alloc.request_size) + ffpa_pkg::RQ_W'(7))
                      & ~ffpa_pkg::RQ_W'(7);

    // Initialize rounds the configured size down to eight bytes and clamps it.
    assign ps_trunc = r_pool_size & ~ffpa_pkg::CFG_W'(7);
    assign ps_clamp = (ps_trunc > CAP_C) ? CAP_C :
                      (ps_trunc < MIN_C) ? MIN_C : ps_trunc;

    // A free is ignored unless its offset is a nonzero multiple of eight whose
    // header lies inside the pool.
    assign free_bad = (i_alloc.block_offset < ffpa_pkg::OFF_W'(ffpa_pkg::HEADER_BYTES))
                   || (i_alloc.block_offset[2:0] != 3'd0)
                   || (ffpa_pkg::ADR_W'(i_alloc.block_offset) > POOL_A);

    assign i_alloc.ready           = (r_state == ffpa_pkg::ST_IDLE);
    assign o_result.valid          = r_out_valid;
    assign o_result.status         = r_out_status;
    assign o_result.payload_offset = r_out_pay;

    ffpa_mem #(
        .DEPTH (POOL_WORDS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    ffpa_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_sum (alu_sum)
    );

    // The adder's operands come from the state, the registers and the memory read
    // data only, so the adder output can feed the next-state logic without a loop.
    always_comb begin
        alu_op = ffpa_pkg::ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        case (r_state)
            ffpa_pkg::ST_A_LATS: begin
                // Size plus header, used to step to the next block.
                alu_a = ffpa_pkg::ADR_W'(mem_rdata);
                alu_b = HDR_A;
            end
            ffpa_pkg::ST_A_EVAL: begin
                // Byte offset of the header after this block.
                alu_a = r_adr;
                alu_b = r_s8;
            end
            ffpa_pkg::ST_M_SUM: begin
                // Merged size: this size, header and following size.
                alu_a = r_s8;
                alu_b = ffpa_pkg::ADR_W'(mem_rdata);
            end
            ffpa_pkg::ST_SP_NX: begin
                // Header of the free remainder after a split.
                alu_a = r_adr;
                alu_b = ffpa_pkg::ADR_W'(r_req8);
            end
            ffpa_pkg::ST_SP_W1: begin
                // Size of the free remainder.
                alu_op = ffpa_pkg::ALU_SUB;
                alu_a  = ffpa_pkg::ADR_W'(r_s);
                alu_b  = ffpa_pkg::ADR_W'(r_req8);
            end
            default: begin
            end
        endcase
    end

    // Next state, working registers and memory port.
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_adr        = r_adr;
        n_nx         = r_nx;
        n_req        = r_req;
        n_req8       = r_req8;
        n_f          = r_f;
        n_s          = r_s;
        n_s8         = r_s8;
        n_big        = r_big;
        n_eq         = r_eq;
        n_nf_last    = r_nf_last;
        n_steps      = r_steps;
        n_res_status = r_res_status;
        n_res_pay    = r_res_pay;
        n_out_valid  = r_out_valid && !o_result.ready;
        n_out_status = r_out_status;
        n_out_pay    = r_out_pay;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = adr_idx;
        mem_wdata    = '0;

        case (r_state)
            ffpa_pkg::ST_CLEAR: begin
                // Zero the pool and lay down one free last block over it.
                mem_we   = 1'b1;
                mem_addr = r_clr;
                if (r_clr == AW'(0)) begin
                    mem_wdata = ffpa_pkg::FLAG_FREE | ffpa_pkg::FLAG_LAST;
                end else if (r_clr == AW'(1)) begin
                    mem_wdata = RST_SIZE_W;
                end
                n_clr = r_clr + AW'(1);
                if (r_clr == LAST_IDX) begin
                    n_state = ffpa_pkg::ST_IDLE;
                end
            end

            ffpa_pkg::ST_IDLE: begin
                if (accept) begin
                    n_res_status = 1'b0;
                    n_res_pay    = '0;
                    case (ffpa_pkg::t_opcode'(i_alloc.opcode))
                        ffpa_pkg::OP_ALLOC: begin
                            n_req   = req_rnd;
                            n_req8  = req_rnd + ffpa_pkg::RQ_W'(ffpa_pkg::HEADER_BYTES);
                            n_adr   = '0;
                            n_steps = '0;
                            n_state = ffpa_pkg::ST_A_CHK;
                        end
                        ffpa_pkg::OP_FREE: begin
                            if (free_bad) begin
                                n_state = ffpa_pkg::ST_DONE;
                            end else begin
                                n_adr   = ffpa_pkg::ADR_W'(i_alloc.block_offset) - HDR_A;
                                n_state = ffpa_pkg::ST_F_RD;
                            end
                        end
                        ffpa_pkg::OP_INIT: begin
                            n_state = ffpa_pkg::ST_I_W0;
                        end
                        default: begin
                            n_state = ffpa_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            ffpa_pkg::ST_A_CHK: begin
                // A runaway walk or a header outside the pool means no space.
                if ((r_steps >= MAX_WALK_C) || !adr_fits) begin
                    n_res_status = 1'b1;
                    n_res_pay    = '0;
                    n_state      = ffpa_pkg::ST_DONE;
                end else begin
                    n_steps = r_steps + SW'(1);
                    mem_re  = 1'b1;
                    n_state = ffpa_pkg::ST_A_RDS;
                end
            end

            ffpa_pkg::ST_A_RDS: begin
                n_f      = mem_rdata;
                mem_re   = 1'b1;
                mem_addr = adr_idx + AW'(1);
                n_state  = ffpa_pkg::ST_A_LATS;
            end

            ffpa_pkg::ST_A_LATS: begin
                n_s     = mem_rdata;
                n_s8    = alu_sum;
                n_big   = (mem_rdata > ffpa_pkg::WORD_W'(r_req8));
                n_eq    = (mem_rdata == ffpa_pkg::WORD_W'(r_req));
                n_state = ffpa_pkg::ST_A_EVAL;
            end

            ffpa_pkg::ST_A_EVAL: begin
                n_nx = alu_sum;
                if ((r_f & ffpa_pkg::FLAG_USED) != '0) begin
                    if ((r_f & ffpa_pkg::FLAG_LAST) != '0) begin
                        n_res_status = 1'b1;
                        n_state      = ffpa_pkg::ST_DONE;
                    end else begin
                        n_adr   = alu_sum;
                        n_state = ffpa_pkg::ST_A_CHK;
                    end
                end else if (((r_f & ffpa_pkg::FLAG_FREE) != '0) && r_big) begin
                    n_state = ffpa_pkg::ST_SP_NX;
                end else if (((r_f & ffpa_pkg::FLAG_FREE) != '0) && r_eq) begin
                    n_state = ffpa_pkg::ST_EX_W;
                end else if (((r_f & ffpa_pkg::FLAG_FREE) != '0)
                          && ((r_f & ffpa_pkg::FLAG_LAST) == '0) && sum_fits) begin
                    // Too small: look at the next block for a lazy merge.
                    n_state = ffpa_pkg::ST_M_RDF;
                end else if ((r_f & ffpa_pkg::FLAG_LAST) != '0) begin
                    n_res_status = 1'b1;
                    n_state      = ffpa_pkg::ST_DONE;
                end else begin
                    n_adr   = alu_sum;
                    n_state = ffpa_pkg::ST_A_CHK;
                end
            end

            ffpa_pkg::ST_M_RDF: begin
                mem_re   = 1'b1;
                mem_addr = nx_idx;
                n_state  = ffpa_pkg::ST_M_RDS;
            end

            ffpa_pkg::ST_M_RDS: begin
                if ((mem_rdata & ffpa_pkg::FLAG_FREE) != '0) begin
                    n_nf_last = ((mem_rdata & ffpa_pkg::FLAG_LAST) != '0);
                    mem_re    = 1'b1;
                    mem_addr  = nx_idx + AW'(1);
                    n_state   = ffpa_pkg::ST_M_SUM;
                end else begin
                    n_adr   = r_nx;
                    n_state = ffpa_pkg::ST_A_CHK;
                end
            end

            ffpa_pkg::ST_M_SUM: begin
                // The merged size wraps at 32 bits like the stored word.
                mem_we    = 1'b1;
                mem_addr  = adr_idx + AW'(1);
                mem_wdata = alu_sum[ffpa_pkg::WORD_W-1:0];
                n_state   = r_nf_last ? ffpa_pkg::ST_M_LAST : ffpa_pkg::ST_A_CHK;
            end

            ffpa_pkg::ST_M_LAST: begin
                mem_we    = 1'b1;
                mem_wdata = r_f | ffpa_pkg::FLAG_LAST;
                n_state   = ffpa_pkg::ST_A_CHK;
            end

            ffpa_pkg::ST_SP_NX: begin
                n_nx = alu_sum;
                if (sum_fits) begin
                    n_state = ffpa_pkg::ST_SP_W0;
                end else begin
                    n_res_status = 1'b1;
                    n_state      = ffpa_pkg::ST_DONE;
                end
            end

            ffpa_pkg::ST_SP_W0: begin
                mem_we    = 1'b1;
                mem_addr  = nx_idx;
                mem_wdata = ffpa_pkg::FLAG_FREE | (r_f & ffpa_pkg::FLAG_LAST);
                n_state   = ffpa_pkg::ST_SP_W1;
            end

            ffpa_pkg::ST_SP_W1: begin
                mem_we    = 1'b1;
                mem_addr  = nx_idx + AW'(1);
                mem_wdata = alu_sum[ffpa_pkg::WORD_W-1:0];
                n_state   = ffpa_pkg::ST_SP_W2;
            end

            ffpa_pkg::ST_SP_W2: begin
                mem_we    = 1'b1;
                mem_wdata = ffpa_pkg::FLAG_USED;
                n_state   = ffpa_pkg::ST_SP_W3;
            end

            ffpa_pkg::ST_SP_W3: begin
                mem_we       = 1'b1;
                mem_addr     = adr_idx + AW'(1);
                mem_wdata    = ffpa_pkg::WORD_W'(r_req);
                n_res_status = 1'b0;
                n_res_pay    = r_adr[ffpa_pkg::PAY_W-1:0]
                             + ffpa_pkg::PAY_W'(ffpa_pkg::HEADER_BYTES);
                n_state      = ffpa_pkg::ST_DONE;
            end

            ffpa_pkg::ST_EX_W: begin
                mem_we       = 1'b1;
                mem_wdata    = (r_f & ~ffpa_pkg::FLAG_FREE) | ffpa_pkg::FLAG_USED;
                n_res_status = 1'b0;
                n_res_pay    = r_adr[ffpa_pkg::PAY_W-1:0]
                             + ffpa_pkg::PAY_W'(ffpa_pkg::HEADER_BYTES);
                n_state      = ffpa_pkg::ST_DONE;
            end

            ffpa_pkg::ST_F_RD: begin
                mem_re  = 1'b1;
                n_state = ffpa_pkg::ST_F_WR;
            end

            ffpa_pkg::ST_F_WR: begin
                mem_we    = 1'b1;
                mem_wdata = (mem_rdata | ffpa_pkg::FLAG_FREE) & ~ffpa_pkg::FLAG_USED;
                n_state   = ffpa_pkg::ST_DONE;
            end

            ffpa_pkg::ST_I_W0: begin
                mem_we    = 1'b1;
                mem_addr  = AW'(0);
                mem_wdata = ffpa_pkg::FLAG_FREE | ffpa_pkg::FLAG_LAST;
                n_state   = ffpa_pkg::ST_I_W1;
            end

            ffpa_pkg::ST_I_W1: begin
                mem_we    = 1'b1;
                mem_addr  = AW'(1);
                mem_wdata = ffpa_pkg::WORD_W'(ps_clamp)
                          - ffpa_pkg::WORD_W'(ffpa_pkg::HEADER_BYTES);
                n_state   = ffpa_pkg::ST_DONE;
            end

            ffpa_pkg::ST_DONE: begin
                // Hand the result to the output register once it is free.
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_pay    = r_res_pay;
                    n_state      = ffpa_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = ffpa_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffpa_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_pool_size <= ffpa_pkg::POOL_SIZE_RST;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_pool_size <= i_cfg_wdata;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_adr        <= n_adr;
        r_nx         <= n_nx;
        r_req        <= n_req;
        r_req8       <= n_req8;
        r_f          <= n_f;
        r_s          <= n_s;
        r_s8         <= n_s8;
        r_big        <= n_big;
        r_eq         <= n_eq;
        r_nf_last    <= n_nf_last;
        r_steps      <= n_steps;
        r_res_status <= n_res_status;
        r_res_pay    <= n_res_pay;
        r_out_status <= n_out_status;
        r_out_pay    <= n_out_pay;
    end

`ifndef SYNTH
    // The pool is never written while the block waits for a word.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffpa_pkg::ST_IDLE) |-> !mem_we)
        else $error("pool written while idle");

    // Every accepted word starts work in the next cycle.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != ffpa_pkg::ST_IDLE))
        else $error("accepted word did not start");

    // The walk counter never passes its limit.
    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffpa_pkg::ST_A_CHK) |-> (r_steps <= MAX_WALK_C))
        else $error("walk counter overran");

    // A failed allocate always reports offset zero.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ffpa_pkg::ST_DONE) && r_res_status) |-> (r_res_pay == '0))
        else $error("failed allocate with nonzero offset");
`endif

endmodule

// ===== test/tb_top.sv =====
// Testbench for the first-fit pool allocator.
//
// A queue of pending words feeds a clocked driver. Each word the block
// accepts is run at once through a model of the pool kept here: header words
// in a 1024-entry array, the same first-fit walk, splits, lazy merges,
// frees and initializes. The predicted result goes into a queue. A clocked
// monitor takes each result word the block hands out and compares it,
// field by field, with the oldest prediction.
//
// The run starts with a short directed part. It covers zero and maximum
// requests, exact fits, splits, the near fit that forces a merge, bad frees,
// the unknown opcode and the pool size extremes. After that come random
// phases, each with its own pool size and started by an initialize. Most
// words allocate or free blocks that are really live, so the chain of
// headers grows deep. The rest are stray frees, initializes and unknown
// opcodes.
module tb_top;
    import ffpa_pkg::*;

    localparam int POOL_BYTES   = POOL_BYTES_DEF;
    localparam int POOL_WORDS   = POOL_BYTES / 4;
    localparam int WALK_LIMIT   = POOL_BYTES / 4 + 4;
    // The longest correct gap is a walk over every header plus merges,
    // or the clearing pass right after reset.
    localparam int STALL_LIMIT  = 40000;
    localparam int PHASE_WORDS  = 200;
    localparam int PHASE_COUNT  = 8;
    localparam int LIVE_MAX     = 64;
    localparam int QUEUE_AHEAD  = 4;
    localparam int LONG_HOLD    = 400;

    localparam logic STAT_OK      = 1'b0;
    localparam logic STAT_NOSPACE = 1'b1;

    typedef struct packed {
        t_opcode             opcode;
        logic [REQ_W-1:0]    request_size;
        logic [OFF_W-1:0]    block_offset;
    } t_alloc_word;

    typedef struct packed {
        logic                status;
        logic [PAY_W-1:0]    payload_offset;
    } t_result_word;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_W-1:0]  i_cfg_wdata;

    ffpa_in_if  alloc_if ();
    ffpa_out_if result_if ();

    first_fit_pool_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_alloc     (alloc_if),
        .o_result    (result_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Pool model: the header words and the pool size register.
    logic [WORD_W-1:0] pool_mem [POOL_WORDS];
    logic [CFG_W-1:0]  pool_size_reg;

    t_alloc_word       pending_words [$];
    t_result_word      predicted_results [$];
    logic [OFF_W-1:0]  live_blocks [$];
    t_alloc_word       word_in_flight;

    // The generator writes idle_on between phases, just after a rising edge. Both
    // clocked sides read it at the rising edge.
    bit  idle_on;
    int  send_gap;
    int  hold_cnt;
    int  quiet_cycles;
    int  words_queued;
    int  results_checked;
    int  mismatch_count;
    int  n_alloc_ok, n_alloc_fail, n_free, n_init, n_nop, n_cfg;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Pool model
    // ------------------------------------------------------------------
    function automatic logic [WORD_W-1:0] pool_rd(logic [63:0] adr);
        logic [63:0] w;
        w = adr >> 2;
        if (w < POOL_WORDS) return pool_mem[w];
        return '0;
    endfunction

    function automatic void pool_wr(logic [63:0] adr, logic [WORD_W-1:0] v);
        logic [63:0] w;
        w = adr >> 2;
        if (w < POOL_WORDS) pool_mem[w] = v;
    endfunction

    function automatic bit header_fits(logic [63:0] adr);
        return (adr + HEADER_BYTES) <= POOL_BYTES;
    endfunction

    // An initialize rounds the register down to a multiple of 8 and clamps it
    // into the range that the pool can hold. Then it writes one free last block.
    function automatic void pool_format();
        int unsigned span;
        int unsigned cap;
        span = 32'(pool_size_reg) & 32'hFFFF_FFF8;
        cap  = SIZE_CAP;
        if ((POOL_BYTES & ~7) < cap) cap = POOL_BYTES & ~7;
        if (span > cap) span = cap;
        if (span < MIN_POOL) span = MIN_POOL;
        pool_wr(0, FLAG_FREE | FLAG_LAST);
        pool_wr(4, span - HEADER_BYTES);
    endfunction

    // The walk returns the payload offset of the block taken, or 0 when
    // nothing fits. Payload offsets are never 0, but one of 4096 wraps to 0
    // in the 12-bit field.
    function automatic logic [63:0] first_fit(logic [REQ_W-1:0] request);
        logic [63:0]       rq, adr, nx, payload;
        logic [WORD_W-1:0] f, s, nf, ns;
        int unsigned       steps;
        bit                done, merged;
        rq      = (64'(request) + 64'd7) & ~64'd7;
        adr     = '0;
        payload = '0;
        steps   = 0;
        done    = 1'b0;
        while (!done) begin
            if (steps >= WALK_LIMIT || !header_fits(adr)) begin
                // A broken chain ends the walk with no space.
                done = 1'b1;
            end else begin
                steps++;
                f      = pool_rd(adr);
                s      = pool_rd(adr + 4);
                merged = 1'b0;
                if ((f & FLAG_USED) == 0 && (f & FLAG_FREE) != 0) begin
                    if (64'(s) > rq + HEADER_BYTES) begin
                        // Split the block. The tail becomes a new free block
                        // and keeps the last flag.
                        nx   = adr + rq + HEADER_BYTES;
                        done = 1'b1;
                        if (header_fits(nx)) begin
                            pool_wr(nx, FLAG_FREE | (f & FLAG_LAST));
                            pool_wr(nx + 4, 32'(64'(s) - (rq + HEADER_BYTES)));
                            pool_wr(adr, FLAG_USED);
                            pool_wr(adr + 4, 32'(rq));
                            payload = adr + HEADER_BYTES;
                        end
                    end else if (64'(s) == rq) begin
                        pool_wr(adr, (f & ~FLAG_FREE) | FLAG_USED);
                        payload = adr + HEADER_BYTES;
                        done    = 1'b1;
                    end else if ((f & FLAG_LAST) == 0) begin
                        // Too small, or only 8 bytes too large. Merge with a
                        // free neighbor and test the same block again.
                        nx = adr + 64'(s) + HEADER_BYTES;
                        if (header_fits(nx)) begin
                            nf = pool_rd(nx);
                            if ((nf & FLAG_FREE) != 0) begin
                                ns = s + pool_rd(nx + 4) + HEADER_BYTES;
                                pool_wr(adr + 4, ns);
                                if ((nf & FLAG_LAST) != 0) pool_wr(adr, f | FLAG_LAST);
                                merged = 1'b1;
                            end
                        end
                    end
                end
                if (!done && !merged) begin
                    if ((f & FLAG_LAST) != 0) done = 1'b1;
                    else adr = adr + 64'(s) + HEADER_BYTES;
                end
            end
        end
        return payload;
    endfunction

    // A free checks the offset and then sets the free flag of the header.
    // Blocks are never merged here.
    function automatic void block_release(logic [OFF_W-1:0] off);
        logic [63:0] hdr;
        if (off < HEADER_BYTES || off[2:0] != 3'd0) return;
        hdr = 64'(off) - HEADER_BYTES;
        if (!header_fits(hdr)) return;
        pool_wr(hdr, (pool_rd(hdr) | FLAG_FREE) & ~FLAG_USED);
    endfunction

    function automatic t_result_word pool_model_step(t_alloc_word w);
        t_result_word r;
        logic [63:0]  p;
        r = '0;
        r.status = STAT_OK;
        case (w.opcode)
            OP_ALLOC: begin
                p = first_fit(w.request_size);
                if (p == 0) r.status = STAT_NOSPACE;
                else r.payload_offset = p[PAY_W-1:0];
            end
            OP_FREE: block_release(w.block_offset);
            OP_INIT: pool_format();
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting. Every mismatch prints one line and is counted.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("MISMATCH result %0d: %s got %0d expected %0d",
                 results_checked, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers the pending words one by one. It predicts each word at
    // the edge where it is accepted and, while idle_on is set, inserts idle bursts.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            alloc_if.valid        <= 1'b0;
            alloc_if.opcode       <= OP_NOP;
            alloc_if.request_size <= '0;
            alloc_if.block_offset <= '0;
            send_gap = 0;
        end else begin
            if (alloc_if.valid && alloc_if.ready) begin
                t_result_word r;
                r = pool_model_step(word_in_flight);
                predicted_results.push_back(r);
                case (word_in_flight.opcode)
                    OP_ALLOC: begin
                        if (r.status == STAT_OK) begin
                            n_alloc_ok++;
                            if (live_blocks.size() < LIVE_MAX && r.payload_offset != 0)
                                live_blocks.push_back(r.payload_offset);
                        end else begin
                            n_alloc_fail++;
                        end
                    end
                    OP_FREE: n_free++;
                    OP_INIT: n_init++;
                    default: n_nop++;
                endcase
            end
            // The slot is free when nothing is offered or the offer was just
            // taken. Otherwise the current word must stay put.
            if (!alloc_if.valid || alloc_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    alloc_if.valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 8);
                    alloc_if.valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    word_in_flight = pending_words.pop_front();
                    alloc_if.valid        <= 1'b1;
                    alloc_if.opcode       <= word_in_flight.opcode;
                    alloc_if.request_size <= word_in_flight.request_size;
                    alloc_if.block_offset <= word_in_flight.block_offset;
                end else begin
                    alloc_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result word against the oldest prediction.
    // Twice in the run it holds ready low for a long stretch. The driver
    // keeps offering words meanwhile, so the block fills its output register
    // and then stops taking input.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
            hold_cnt = 0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                t_result_word want;
                if (predicted_results.size() == 0) begin
                    report_mismatch("result with nothing pending, payload",
                                    int'(result_if.payload_offset), 0);
                end else begin
                    want = predicted_results.pop_front();
                    if (result_if.status !== want.status)
                        report_mismatch("status", int'(result_if.status), int'(want.status));
                    if (result_if.payload_offset !== want.payload_offset)
                        report_mismatch("payload_offset", int'(result_if.payload_offset),
                                        int'(want.payload_offset));
                end
                results_checked++;
                if (idle_on && results_checked % 700 == 350) hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                result_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                hold_cnt = $urandom_range(0, 8);
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no word moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (alloc_if.valid && alloc_if.ready) ||
            (result_if.valid && result_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // The generator stays a few words ahead of the driver. Frees can then
    // pick blocks whose allocation has already been predicted.
    task automatic push_word(input t_opcode op, input logic [REQ_W-1:0] rq,
                             input logic [OFF_W-1:0] off);
        t_alloc_word w;
        while (pending_words.size() >= QUEUE_AHEAD) @(negedge i_clk);
        w.opcode       = op;
        w.request_size = rq;
        w.block_offset = off;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Waits until every queued word has produced its result. Then it lets
    // the block settle before the register is touched.
    task automatic settle_pool();
        do @(negedge i_clk); while (results_checked < words_queued);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_pool_size(input logic [CFG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        pool_size_reg = v;
        n_cfg++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [REQ_W-1:0] random_request();
        int k;
        k = $urandom_range(0, 19);
        if (k < 12) return REQ_W'($urandom_range(0, 64));
        if (k < 17) return REQ_W'($urandom_range(65, 512));
        if (k < 19) return REQ_W'($urandom_range(513, 4096));
        return REQ_W'($urandom_range(4097, 8191));
    endfunction

    // Mostly allocates and frees live blocks. The rest are stray frees,
    // initializes and unknown opcodes, with random values in the unused fields.
    task automatic push_random_word();
        int               pick, idx;
        logic [OFF_W-1:0] off;
        pick = $urandom_range(0, 99);
        if (pick < 83 && pick >= 48 && live_blocks.size() != 0) begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            off = live_blocks[idx];
            live_blocks.delete(idx);
            push_word(OP_FREE, REQ_W'($urandom), off);
        end else if (pick < 83) begin
            push_word(OP_ALLOC, random_request(), OFF_W'($urandom));
        end else if (pick < 91) begin
            off = OFF_W'($urandom);
            if ($urandom_range(0, 1) == 0) off[2:0] = 3'd0;
            push_word(OP_FREE, REQ_W'($urandom), off);
        end else if (pick < 95) begin
            push_word(OP_INIT, REQ_W'($urandom), OFF_W'($urandom));
            live_blocks.delete();
        end else begin
            push_word(OP_NOP, REQ_W'($urandom), OFF_W'($urandom));
        end
    endtask

    initial begin
        logic [CFG_W-1:0] phase_size;
        int               phase, n;

        // Reset and configuration start known; the channel signals are set
        // by the driver and the monitor while reset is held.
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_wdata           = '0;
        idle_on               = 1'b1;

        // State after reset: an empty pool with one free last block.
        foreach (pool_mem[i]) pool_mem[i] = '0;
        pool_size_reg = POOL_SIZE_RST;
        pool_format();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, full pool first.
        push_word(OP_ALLOC, 13'd0, 12'd0);       // zero request, split off block 0
        push_word(OP_ALLOC, 13'd1, 12'd0);       // rounds up to 8
        push_word(OP_ALLOC, 13'd4096, 12'd0);    // largest legal request, no space
        push_word(OP_ALLOC, 13'd8191, 12'hFFF);  // all ones in the request field
        push_word(OP_FREE, 13'd0, 12'd8);
        push_word(OP_ALLOC, 13'd0, 12'd0);       // exact fit of the zero block
        push_word(OP_ALLOC, 13'd16, 12'd0);
        push_word(OP_FREE, 13'd0, 12'd32);
        push_word(OP_ALLOC, 13'd8, 12'd0);       // block only 8 too large: merge first
        push_word(OP_FREE, 13'd0, 12'd0);        // below the first payload
        push_word(OP_FREE, 13'd0, 12'd12);       // not a multiple of 8
        push_word(OP_FREE, 13'd0, 12'd4095);
        push_word(OP_FREE, 13'd0, 12'd4088);     // header slot at the pool end
        push_word(OP_NOP, 13'h1FFF, 12'hFFF);
        push_word(OP_INIT, 13'd0, 12'd0);
        push_word(OP_ALLOC, 13'd4088, 12'd0);    // the whole pool in one block
        settle_pool();

        // Smallest pool: one block of 8 bytes.
        write_pool_size(13'd16);
        push_word(OP_INIT, 13'd0, 12'd0);
        push_word(OP_ALLOC, 13'd8, 12'd0);
        push_word(OP_ALLOC, 13'd0, 12'd0);
        push_word(OP_FREE, 13'd0, 12'd8);
        push_word(OP_ALLOC, 13'd0, 12'd0);       // near fit in the last block fails
        settle_pool();

        // Oversized register value, clamped to the pool.
        write_pool_size(13'h1FFF);
        push_word(OP_INIT, 13'd0, 12'd0);
        push_word(OP_ALLOC, 13'd4089, 12'd0);
        settle_pool();

        // Zero register value, raised to the minimum.
        write_pool_size(13'd0);
        push_word(OP_INIT, 13'd0, 12'd0);
        push_word(OP_ALLOC, 13'd1, 12'd0);

        // Random phases, each with its own pool size. Phase 3 runs without
        // idling, and so does the last phase.
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            settle_pool();
            case (phase)
                0: phase_size = 13'd4096;
                1: phase_size = 13'd1024;
                2: phase_size = CFG_W'($urandom_range(16, 4096));
                3: phase_size = 13'd4095;
                4: phase_size = 13'd8191;
                5: phase_size = 13'd17;
                6: phase_size = CFG_W'($urandom_range(0, 8191));
                default: phase_size = 13'd4096;
            endcase
            write_pool_size(phase_size);
            idle_on = (phase != 3 && phase != PHASE_COUNT - 1);
            push_word(OP_INIT, REQ_W'($urandom), OFF_W'($urandom));
            live_blocks.delete();
            for (n = 1; n < PHASE_WORDS; n++) push_random_word();
        end

        settle_pool();
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d allocations (%0d without space), %0d frees,",
                 n_alloc_ok + n_alloc_fail, n_alloc_fail, n_free);
        $display("%0d initializes and %0d unknown opcodes over %0d pool size settings.",
                 n_init, n_nop, n_cfg);
        if (mismatch_count == 0 && predicted_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
